/* hdl/lpi_pkg.sv */
// ----------------------------------------------------------------------------
// lpi_pkg
// Shared types and constants for the line pair intersection core.
// ----------------------------------------------------------------------------
package lpi_pkg;

	// coordinate width default, result width, pipeline depths
	localparam int COORD_W_DEF = 16;
	localparam int OUT_W       = 32;
	localparam int FRONT_LAT   = 4;
	localparam int DIV_LAT     = OUT_W + 3;
	localparam int TOTAL_LAT   = FRONT_LAT + DIV_LAT + 1;

	typedef enum logic [1:0] {
		OUT_NONE   = 2'd0,
		OUT_CROSS  = 2'd1,
		OUT_SHARED = 2'd2
	} outcome_t;

	// travels alongside the divider: fallback point for a zero determinant
	typedef struct packed {
		logic             det_zero;
		logic             shared;
		logic [OUT_W-1:0] px;
		logic [OUT_W-1:0] py;
	} side_t;

endpackage

/* hdl/lpi_front.sv */
// ----------------------------------------------------------------------------
// lpi_front
// Line coefficients, determinant and the two numerators, four stages.
// ----------------------------------------------------------------------------
module lpi_front #(
	parameter int COORD_W = lpi_pkg::COORD_W_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic signed [COORD_W-1:0]     p1x,
	input  logic signed [COORD_W-1:0]     p1y,
	input  logic signed [COORD_W-1:0]     p2x,
	input  logic signed [COORD_W-1:0]     p2y,
	input  logic signed [COORD_W-1:0]     q1x,
	input  logic signed [COORD_W-1:0]     q1y,
	input  logic signed [COORD_W-1:0]     q2x,
	input  logic signed [COORD_W-1:0]     q2y,
	output logic                          out_valid,
	output logic signed [3*COORD_W+2:0]   nx,
	output logic signed [3*COORD_W+2:0]   ny,
	output logic signed [2*COORD_W+2:0]   det,
	output lpi_pkg::side_t                side
);
	import lpi_pkg::*;

	localparam int AW = COORD_W + 1;     // a, b
	localparam int PW = 2 * COORD_W;     // coordinate products
	localparam int CD = PW + 1;          // c
	localparam int DP = 2 * AW;          // determinant products
	localparam int DW = DP + 1;          // determinant
	localparam int NP = AW + CD;         // numerator products
	localparam int NW = NP + 1;          // numerators

	logic hit_start, hit_end;
	side_t side_c;

	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [AW-1:0] a1_s1, b1_s1, a2_s1, b2_s1;
	logic signed [PW-1:0] pc11_s1, pc12_s1, pc21_s1, pc22_s1;
	side_t side_s1;

	logic signed [AW-1:0] a1_s2, b1_s2, a2_s2, b2_s2;
	logic signed [CD-1:0] c1_s2, c2_s2;
	logic signed [DP-1:0] dp1_s2, dp2_s2;
	side_t side_s2;

	logic signed [DW-1:0] det_s3;
	logic signed [NP-1:0] nxp1_s3, nxp2_s3, nyp1_s3, nyp2_s3;
	side_t side_s3;

	logic signed [NW-1:0] nx_s4, ny_s4;
	logic signed [DW-1:0] det_s4;
	side_t side_s4;

	// shared endpoint search, first line's start has priority over its end
	always_comb begin
		hit_start = (p1x == q1x && p1y == q1y) || (p1x == q2x && p1y == q2y);
		hit_end   = (p2x == q1x && p2y == q1y) || (p2x == q2x && p2y == q2y);
		side_c.det_zero = 1'b0;
		side_c.shared   = hit_start | hit_end;
		if (hit_start) begin
			side_c.px = OUT_W'(p1x);
			side_c.py = OUT_W'(p1y);
		end else if (hit_end) begin
			side_c.px = OUT_W'(p2x);
			side_c.py = OUT_W'(p2y);
		end else begin
			side_c.px = '0;
			side_c.py = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		a1_s1   <= AW'(p1y) - AW'(p2y);
		b1_s1   <= AW'(p2x) - AW'(p1x);
		a2_s1   <= AW'(q1y) - AW'(q2y);
		b2_s1   <= AW'(q2x) - AW'(q1x);
		pc11_s1 <= PW'(p1x) * PW'(p2y);
		pc12_s1 <= PW'(p2x) * PW'(p1y);
		pc21_s1 <= PW'(q1x) * PW'(q2y);
		pc22_s1 <= PW'(q2x) * PW'(q1y);
		side_s1 <= side_c;

		c1_s2   <= CD'(pc11_s1) - CD'(pc12_s1);
		c2_s2   <= CD'(pc21_s1) - CD'(pc22_s1);
		dp1_s2  <= DP'(a1_s1) * DP'(b2_s1);
		dp2_s2  <= DP'(a2_s1) * DP'(b1_s1);
		a1_s2   <= a1_s1;
		b1_s2   <= b1_s1;
		a2_s2   <= a2_s1;
		b2_s2   <= b2_s1;
		side_s2 <= side_s1;

		det_s3  <= DW'(dp1_s2) - DW'(dp2_s2);
		nxp1_s3 <= NP'(b1_s2) * NP'(c2_s2);
		nxp2_s3 <= NP'(b2_s2) * NP'(c1_s2);
		nyp1_s3 <= NP'(c1_s2) * NP'(a2_s2);
		nyp2_s3 <= NP'(c2_s2) * NP'(a1_s2);
		side_s3 <= side_s2;

		nx_s4   <= NW'(nxp1_s3) - NW'(nxp2_s3);
		ny_s4   <= NW'(nyp1_s3) - NW'(nyp2_s3);
		det_s4  <= det_s3;
		side_s4 <= {(det_s3 == '0), side_s3.shared, side_s3.px, side_s3.py};
	end

	assign out_valid = v_s4;
	assign nx        = nx_s4;
	assign ny        = ny_s4;
	assign det       = det_s4;
	assign side      = side_s4;

endmodule

/* hdl/lpi_div.sv */
// ----------------------------------------------------------------------------
// lpi_div
// Pipelined signed divider, one quotient bit per stage, truncates toward
// zero and saturates the quotient to QUO_W bits.
// ----------------------------------------------------------------------------
module lpi_div #(
	parameter int NUM_W = 51,
	parameter int DEN_W = 35,
	parameter int QUO_W = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic signed [NUM_W-1:0] num,
	input  logic signed [DEN_W-1:0] den,
	output logic                    out_valid,
	output logic signed [QUO_W-1:0] quo,
	output logic                    clip
);
	localparam int RW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;
	localparam logic [QUO_W-1:0] QMAX = {1'b0, {(QUO_W-1){1'b1}}};
	localparam logic [QUO_W-1:0] QMIN = {1'b1, {(QUO_W-1){1'b0}}};

	logic             v_s1, neg_s1;
	logic [NUM_W-1:0] nmag_s1;
	logic [DEN_W-1:0] dmag_s1;

	// element 0 is the overflow check stage, element k+1 follows bit step k
	logic             it_v_s   [0:QUO_W];
	logic             it_neg_s [0:QUO_W];
	logic             it_ovf_s [0:QUO_W];
	logic [RW-1:0]    it_rem_s [0:QUO_W];
	logic [DEN_W-1:0] it_den_s [0:QUO_W];
	logic [QUO_W-1:0] it_quo_s [0:QUO_W];

	logic [QUO_W-1:0] mag;
	logic [QUO_W-1:0] res_c;
	logic             clip_c;
	logic             v_q, clip_q;
	logic [QUO_W-1:0] res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			it_v_s[0]   <= 1'b0;
		end else begin
			v_s1        <= in_valid;
			it_v_s[0]   <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		neg_s1      <= num[NUM_W-1] ^ den[DEN_W-1];
		nmag_s1     <= num[NUM_W-1] ? $unsigned(-num) : $unsigned(num);
		dmag_s1     <= den[DEN_W-1] ? $unsigned(-den) : $unsigned(den);

		// quotient needs more than QUO_W bits
		it_ovf_s[0] <= RW'(nmag_s1) >= (RW'(dmag_s1) << QUO_W);
		it_neg_s[0] <= neg_s1;
		it_rem_s[0] <= RW'(nmag_s1);
		it_den_s[0] <= dmag_s1;
		it_quo_s[0] <= '0;
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic [RW-1:0] sh;
		logic          fit;

		assign sh  = RW'(it_den_s[k]) << (QUO_W - 1 - k);
		assign fit = it_rem_s[k] >= sh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				it_v_s[k+1] <= 1'b0;
			end else begin
				it_v_s[k+1] <= it_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			it_rem_s[k+1] <= fit ? it_rem_s[k] - sh : it_rem_s[k];
			it_quo_s[k+1] <= {it_quo_s[k][QUO_W-2:0], fit};
			it_den_s[k+1] <= it_den_s[k];
			it_neg_s[k+1] <= it_neg_s[k];
			it_ovf_s[k+1] <= it_ovf_s[k];
		end
	end

	assign mag = it_quo_s[QUO_W];

	always_comb begin
		if (it_ovf_s[QUO_W]) begin
			clip_c = 1'b1;
			res_c  = it_neg_s[QUO_W] ? QMIN : QMAX;
		end else if (it_neg_s[QUO_W]) begin
			clip_c = mag > QMIN;
			res_c  = clip_c ? QMIN : -mag;
		end else begin
			clip_c = mag[QUO_W-1];
			res_c  = clip_c ? QMAX : mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= it_v_s[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		res_q  <= res_c;
		clip_q <= clip_c;
	end

	assign out_valid = v_q;
	assign quo       = res_q;
	assign clip      = clip_q;

endmodule

/* hdl/line_pair_intersection_core.sv */
// ----------------------------------------------------------------------------
// line_pair_intersection_core
// Crossing point of two lines given by two points each (Cramer's rule).
// ----------------------------------------------------------------------------
// Fully pipelined: a transaction may be started on every clock, busy is
// always low, and each result appears on done for one cycle once its start
// has passed through 4 stages of products and differences, 35 stages of the
// bit-per-stage dividers and one output register. The receiver cannot hold
// results off and nothing is buffered beyond the pipeline itself. Points are
// in the input's fixed-point format; the quotient keeps the input's fraction
// bits with 32-bit saturation. With a zero determinant the first line's
// endpoint shared with the second line is returned, its start first.
module line_pair_intersection_core #(
	parameter int COORD_W = lpi_pkg::COORD_W_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [COORD_W-1:0]         first_start_x,
	input  logic signed [COORD_W-1:0]         first_start_y,
	input  logic signed [COORD_W-1:0]         first_end_x,
	input  logic signed [COORD_W-1:0]         first_end_y,
	input  logic signed [COORD_W-1:0]         second_start_x,
	input  logic signed [COORD_W-1:0]         second_start_y,
	input  logic signed [COORD_W-1:0]         second_end_x,
	input  logic signed [COORD_W-1:0]         second_end_y,
	output logic                              done,
	output logic [1:0]                        outcome,
	output logic signed [lpi_pkg::OUT_W-1:0]  point_x,
	output logic signed [lpi_pkg::OUT_W-1:0]  point_y,
	output logic                              clipped
);
	import lpi_pkg::*;

	localparam int NW = 3 * COORD_W + 3;
	localparam int DW = 2 * COORD_W + 3;

	logic                 fr_valid;
	logic signed [NW-1:0] fr_nx, fr_ny;
	logic signed [DW-1:0] fr_det;
	side_t                fr_side;

	logic                    vx, vy;
	logic signed [OUT_W-1:0] qx, qy;
	logic                    clx, cly;

	side_t side_d [1:DIV_LAT];
	side_t sd;

	logic             done_q;
	outcome_t         outcome_q;
	logic [OUT_W-1:0] px_q, py_q;
	logic             clip_q;

	assign busy = 1'b0;

	lpi_front #(
		.COORD_W(COORD_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.p1x       (first_start_x),
		.p1y       (first_start_y),
		.p2x       (first_end_x),
		.p2y       (first_end_y),
		.q1x       (second_start_x),
		.q1y       (second_start_y),
		.q2x       (second_end_x),
		.q2y       (second_end_y),
		.out_valid (fr_valid),
		.nx        (fr_nx),
		.ny        (fr_ny),
		.det       (fr_det),
		.side      (fr_side)
	);

	lpi_div #(
		.NUM_W(NW),
		.DEN_W(DW),
		.QUO_W(OUT_W)
	) u_div_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.num       (fr_nx),
		.den       (fr_det),
		.out_valid (vx),
		.quo       (qx),
		.clip      (clx)
	);

	lpi_div #(
		.NUM_W(NW),
		.DEN_W(DW),
		.QUO_W(OUT_W)
	) u_div_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.num       (fr_ny),
		.den       (fr_det),
		.out_valid (vy),
		.quo       (qy),
		.clip      (cly)
	);

	// fallback info rides along with the divider latency
	always_ff @(posedge clk) begin
		side_d[1] <= fr_side;
		for (int k = 2; k <= DIV_LAT; k++) begin
			side_d[k] <= side_d[k-1];
		end
	end

	assign sd = side_d[DIV_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vx & vy;
		end
	end

	always_ff @(posedge clk) begin
		if (!sd.det_zero) begin
			outcome_q <= OUT_CROSS;
			px_q      <= qx;
			py_q      <= qy;
			clip_q    <= clx | cly;
		end else if (sd.shared) begin
			outcome_q <= OUT_SHARED;
			px_q      <= sd.px;
			py_q      <= sd.py;
			clip_q    <= 1'b0;
		end else begin
			outcome_q <= OUT_NONE;
			px_q      <= '0;
			py_q      <= '0;
			clip_q    <= 1'b0;
		end
	end

	assign done    = done_q;
	assign outcome = outcome_q;
	assign point_x = px_q;
	assign point_y = py_q;
	assign clipped = clip_q;

`ifndef SYNTH
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##TOTAL_LAT done)
		else $error("transaction result missing");

	a_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, TOTAL_LAT))
		else $error("result without a started transaction");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && outcome == OUT_NONE |-> point_x == '0 && point_y == '0 && !clipped)
		else $error("no-point result carries data");

	a_shared_noclip: assert property (@(posedge clk) disable iff (!arst_n)
		done && outcome == OUT_SHARED |-> !clipped)
		else $error("shared endpoint flagged as clipped");
`endif

endmodule

/* tb/sv/lpi_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpi_checker
// Watches the start and done channels of the line pair intersection core.
// Each accepted transaction gets a predicted crossing point. The predictor
// uses exact 64-bit products and truncating division. Every result is
// compared field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module lpi_checker #(
	parameter int CW = lpi_pkg::COORD_W_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             busy,
	input  logic signed [CW-1:0]             first_start_x,
	input  logic signed [CW-1:0]             first_start_y,
	input  logic signed [CW-1:0]             first_end_x,
	input  logic signed [CW-1:0]             first_end_y,
	input  logic signed [CW-1:0]             second_start_x,
	input  logic signed [CW-1:0]             second_start_y,
	input  logic signed [CW-1:0]             second_end_x,
	input  logic signed [CW-1:0]             second_end_y,
	input  logic                             done,
	input  logic [1:0]                       outcome,
	input  logic signed [lpi_pkg::OUT_W-1:0] point_x,
	input  logic signed [lpi_pkg::OUT_W-1:0] point_y,
	input  logic                             clipped,
	output int                               fail_count,
	output int                               pending
);
	import lpi_pkg::*;

	localparam longint SAT_HI = 64'sd2147483647;
	localparam longint SAT_LO = -64'sd2147483648;

	typedef struct packed {
		outcome_t         kind;
		logic [OUT_W-1:0] px;
		logic [OUT_W-1:0] py;
		logic             clip;
	} crossing_t;

	crossing_t crossing_q[$];
	crossing_t oldest;
	int        fails  = 0;
	int        queued = 0;

	assign fail_count = fails;
	assign pending    = queued;

	function automatic logic [OUT_W-1:0] widen(input logic signed [CW-1:0] v);
		return {{(OUT_W-CW){v[CW-1]}}, v};
	endfunction

	function automatic longint sat_out(input longint v);
		if (v > SAT_HI)
			return SAT_HI;
		if (v < SAT_LO)
			return SAT_LO;
		return v;
	endfunction

	function automatic crossing_t solve_crossing(
		input logic signed [CW-1:0] p1x, p1y, p2x, p2y,
		input logic signed [CW-1:0] q1x, q1y, q2x, q2y
	);
		longint    a1, b1, c1, a2, b2, c2, det, qx, qy;
		crossing_t r;
		r.kind = OUT_NONE;
		r.px   = '0;
		r.py   = '0;
		r.clip = 1'b0;
		a1  = longint'(p1y) - longint'(p2y);
		b1  = longint'(p2x) - longint'(p1x);
		c1  = longint'(p1x) * longint'(p2y) - longint'(p2x) * longint'(p1y);
		a2  = longint'(q1y) - longint'(q2y);
		b2  = longint'(q2x) - longint'(q1x);
		c2  = longint'(q1x) * longint'(q2y) - longint'(q2x) * longint'(q1y);
		det = a1 * b2 - a2 * b1;
		if (det != 0) begin
			// signed division truncates toward zero
			qx     = (b1 * c2 - b2 * c1) / det;
			qy     = (c1 * a2 - c2 * a1) / det;
			r.kind = OUT_CROSS;
			r.clip = (sat_out(qx) != qx) || (sat_out(qy) != qy);
			qx     = sat_out(qx);
			qy     = sat_out(qy);
			r.px   = qx[OUT_W-1:0];
			r.py   = qy[OUT_W-1:0];
		end else if ((p1x == q1x && p1y == q1y) || (p1x == q2x && p1y == q2y)) begin
			r.kind = OUT_SHARED;
			r.px   = widen(p1x);
			r.py   = widen(p1y);
		end else if ((p2x == q1x && p2y == q1y) || (p2x == q2x && p2y == q2y)) begin
			r.kind = OUT_SHARED;
			r.px   = widen(p2x);
			r.py   = widen(p2y);
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [OUT_W-1:0] want,
			input logic [OUT_W-1:0] got);
		if (got !== want) begin
			fails++;
			$display("%0t mismatch on %s: expected %h, actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crossing_q.delete();
			queued <= 0;
		end else begin
			if (done) begin
				if (crossing_q.size() == 0) begin
					fails++;
					$display("%0t unexpected result: expected none, actual outcome %0d x %h y %h clipped %b",
						$time, outcome, point_x, point_y, clipped);
				end else begin
					oldest = crossing_q.pop_front();
					check_field("outcome", OUT_W'(oldest.kind), OUT_W'(outcome));
					check_field("point_x", oldest.px, point_x);
					check_field("point_y", oldest.py, point_y);
					check_field("clipped", OUT_W'(oldest.clip), OUT_W'(clipped));
				end
			end
			if (start && !busy)
				crossing_q.push_back(solve_crossing(first_start_x, first_start_y,
					first_end_x, first_end_y, second_start_x, second_start_y,
					second_end_x, second_end_y));
			queued <= crossing_q.size();
		end
	end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the line pair intersection core: a directed set of crossings,
// parallel and degenerate lines and saturating cases, then random line pairs
// of several shapes with random start gaps. Checking is done by lpi_checker.
// ----------------------------------------------------------------------------
module tb;
	import lpi_pkg::*;

	localparam int CW           = COORD_W_DEF;
	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_ITEMS = 1100;

	typedef struct packed {
		logic signed [CW-1:0] p1x, p1y, p2x, p2y;
		logic signed [CW-1:0] q1x, q1y, q2x, q2y;
	} seg_pair_t;

	logic                    clk            = 1'b0;
	logic                    arst_n         = 1'b0;
	logic                    start          = 1'b0;
	logic signed [CW-1:0]    first_start_x  = '0;
	logic signed [CW-1:0]    first_start_y  = '0;
	logic signed [CW-1:0]    first_end_x    = '0;
	logic signed [CW-1:0]    first_end_y    = '0;
	logic signed [CW-1:0]    second_start_x = '0;
	logic signed [CW-1:0]    second_start_y = '0;
	logic signed [CW-1:0]    second_end_x   = '0;
	logic signed [CW-1:0]    second_end_y   = '0;
	logic                    busy;
	logic                    done;
	logic [1:0]              outcome;
	logic signed [OUT_W-1:0] point_x;
	logic signed [OUT_W-1:0] point_y;
	logic                    clipped;
	int                      fail_count;
	int                      pending;
	int                      idle_cycles = 0;
	bit                      calm        = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	line_pair_intersection_core #(
		.COORD_W(CW)
	) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.first_start_x(first_start_x), .first_start_y(first_start_y),
		.first_end_x(first_end_x), .first_end_y(first_end_y),
		.second_start_x(second_start_x), .second_start_y(second_start_y),
		.second_end_x(second_end_x), .second_end_y(second_end_y),
		.done(done), .outcome(outcome), .point_x(point_x), .point_y(point_y),
		.clipped(clipped)
	);

	lpi_checker #(
		.CW(CW)
	) u_check (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.first_start_x(first_start_x), .first_start_y(first_start_y),
		.first_end_x(first_end_x), .first_end_y(first_end_y),
		.second_start_x(second_start_x), .second_start_y(second_start_y),
		.second_end_x(second_end_x), .second_end_y(second_end_y),
		.done(done), .outcome(outcome), .point_x(point_x), .point_y(point_y),
		.clipped(clipped), .fail_count(fail_count), .pending(pending)
	);

	// watchdog: cycles in which no transaction and no result went through
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic logic signed [CW-1:0] clamp_coord(input int v);
		int hi, lo;
		hi = (1 << (CW - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			v = hi;
		else if (v < lo)
			v = lo;
		return v[CW-1:0];
	endfunction

	function automatic int rnd_int(input int lim);
		return int'($urandom_range(0, 2 * lim)) - lim;
	endfunction

	function automatic logic signed [CW-1:0] rnd_coord(input int lim);
		return clamp_coord(rnd_int(lim));
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(20, 80);
	endfunction

	function automatic seg_pair_t make_pair();
		seg_pair_t s;
		int        dx, dy, ox, oy, k;
		s = {$urandom, $urandom, $urandom, $urandom};
		case ($urandom_range(0, 9))
			4: begin
				// parallel lines, sharing an endpoint now and then
				s.p1x = rnd_coord(8000);
				s.p1y = rnd_coord(8000);
				dx    = rnd_int(8000);
				dy    = rnd_int(8000);
				s.p2x = clamp_coord(s.p1x + dx);
				s.p2y = clamp_coord(s.p1y + dy);
				case ($urandom_range(0, 3))
					0: begin
						ox = 0;
						oy = 0;
					end
					1: begin
						ox = dx;
						oy = dy;
					end
					default: begin
						ox = rnd_int(8000);
						oy = rnd_int(8000);
					end
				endcase
				k     = $urandom_range(0, 1) ? 1 : -1;
				s.q1x = clamp_coord(s.p1x + ox);
				s.q1y = clamp_coord(s.p1y + oy);
				s.q2x = clamp_coord(s.q1x + k * dx);
				s.q2y = clamp_coord(s.q1y + k * dy);
			end
			5: begin
				// second line's endpoints copied from the first line's endpoints or left random
				case ($urandom_range(0, 2))
					0: {s.q1x, s.q1y} = {s.p1x, s.p1y};
					1: {s.q1x, s.q1y} = {s.p2x, s.p2y};
					default: ;
				endcase
				case ($urandom_range(0, 2))
					0: {s.q2x, s.q2y} = {s.p1x, s.p1y};
					1: {s.q2x, s.q2y} = {s.p2x, s.p2y};
					default: ;
				endcase
			end
			6: begin
				// nearly parallel, crossing far away, often saturating
				s.q1x = clamp_coord(s.p1x + rnd_int(3));
				s.q1y = clamp_coord(s.p1y + rnd_int(3));
				s.q2x = clamp_coord(s.p2x + rnd_int(3));
				s.q2y = clamp_coord(s.p2y + rnd_int(3));
			end
			7: begin
				// first line collapsed to a point
				{s.p2x, s.p2y} = {s.p1x, s.p1y};
				case ($urandom_range(0, 2))
					0: {s.q2x, s.q2y} = {s.q1x, s.q1y};
					1: {s.q1x, s.q1y} = {s.p1x, s.p1y};
					default: ;
				endcase
			end
			8, 9: begin
				s.p1x = rnd_coord(4);
				s.p1y = rnd_coord(4);
				s.p2x = rnd_coord(4);
				s.p2y = rnd_coord(4);
				s.q1x = rnd_coord(4);
				s.q1y = rnd_coord(4);
				s.q2x = rnd_coord(4);
				s.q2y = rnd_coord(4);
			end
			default: ;
		endcase
		return s;
	endfunction

	task automatic send(input seg_pair_t s);
		int gap;
		first_start_x  <= s.p1x;
		first_start_y  <= s.p1y;
		first_end_x    <= s.p2x;
		first_end_y    <= s.p2y;
		second_start_x <= s.q1x;
		second_start_y <= s.q1y;
		second_end_x   <= s.q2x;
		second_end_y   <= s.q2y;
		start          <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold off until every predicted result has come back
	task automatic drain();
		start <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		@(posedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		send(seg_pair_t'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
		send(seg_pair_t'{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
			16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
		send(seg_pair_t'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
			16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
		send(seg_pair_t'{-16'sd256, 16'sd0, 16'sd256, 16'sd0,
			16'sd0, -16'sd256, 16'sd0, 16'sd256});
		send(seg_pair_t'{16'sd0, 16'sd0, 16'sd512, 16'sd512,
			16'sd0, 16'sd512, 16'sd512, 16'sd0});
		send(seg_pair_t'{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
			16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000});
		send(seg_pair_t'{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000,
			16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff});
		// zero determinant, each endpoint pairing in turn
		send(seg_pair_t'{16'sd0, 16'sd0, 16'sd256, 16'sd256,
			16'sd0, 16'sd0, 16'sd512, 16'sd512});
		send(seg_pair_t'{16'sd100, 16'sd100, 16'sd200, 16'sd200,
			16'sd300, 16'sd300, 16'sd100, 16'sd100});
		send(seg_pair_t'{16'sd100, 16'sd100, 16'sd200, 16'sd200,
			16'sd200, 16'sd200, 16'sd300, 16'sd300});
		send(seg_pair_t'{16'sd100, 16'sd100, 16'sd200, 16'sd200,
			16'sd400, 16'sd400, 16'sd200, 16'sd200});
		// both ends shared: the first line's start wins
		send(seg_pair_t'{16'sd100, 16'sd100, 16'sd200, 16'sd200,
			16'sd200, 16'sd200, 16'sd100, 16'sd100});
		// parallel and collinear with nothing shared
		send(seg_pair_t'{16'sd0, 16'sd0, 16'sd256, 16'sd0,
			16'sd0, 16'sd256, 16'sd256, 16'sd256});
		send(seg_pair_t'{16'sd0, 16'sd0, 16'sd256, 16'sd0,
			16'sd512, 16'sd0, 16'sd768, 16'sd0});
		// nearly parallel lines meeting beyond the output range
		send(seg_pair_t'{16'sh8000, 16'sd0, 16'sh7fff, 16'sd1,
			16'sh8000, 16'sd1, 16'sh7ffe, 16'sd2});
		send(seg_pair_t'{16'sh7fff, 16'sd0, 16'sh8001, 16'sd1,
			16'sh7fff, 16'sd1, 16'sh8002, 16'sd2});
		send(seg_pair_t'{16'sd0, 16'sh8000, 16'sd1, 16'sh7fff,
			16'sd1, 16'sh8000, 16'sd2, 16'sh7ffe});
		// lines collapsed to points
		send(seg_pair_t'{16'sd50, 16'sd60, 16'sd50, 16'sd60,
			16'sd50, 16'sd60, 16'sd50, 16'sd60});
		send(seg_pair_t'{16'sd50, 16'sd60, 16'sd50, 16'sd60,
			16'sd0, 16'sd0, 16'sd10, 16'sd10});
		// fractional crossings, truncated toward zero on both signs
		send(seg_pair_t'{16'sd0, 16'sd0, 16'sd3, 16'sd1, 16'sd0, 16'sd1, 16'sd1, 16'sd0});
		send(seg_pair_t'{16'sd0, 16'sd0, -16'sd3, 16'sd1,
			16'sd0, 16'sd1, -16'sd1, 16'sd0});

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 100 == 0)
				calm = ($urandom_range(0, 3) == 0);
			if (i == RANDOM_ITEMS / 2)
				drain();
			send(make_pair());
		end

		drain();
		repeat (TOTAL_LAT + 10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
